### src/mnar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnar_pkg
// Shared types and constants for the menu navigation auto-repeat unit.
// ----------------------------------------------------------------------------
package mnar_pkg;

	typedef enum logic [1:0] {
		TIER_NONE   = 2'd0,
		TIER_SLOW   = 2'd1,
		TIER_MEDIUM = 2'd2,
		TIER_FAST   = 2'd3
	} tier_t;

	// step direction, two's complement: -1 up, 0 none, +1 down
	typedef logic [1:0] dir_t;
	localparam dir_t DIR_NONE = 2'b00;
	localparam dir_t DIR_DOWN = 2'b01;
	localparam dir_t DIR_UP   = 2'b11;

	localparam logic [7:0] STICK_CENTRE     = 8'h80;
	localparam logic [7:0] MEDIUM_THRESHOLD = 8'h28;

	typedef enum logic [2:0] {
		REG_DEAD_ZONE       = 3'd0,
		REG_FAST_THRESHOLD  = 3'd1,
		REG_SLOW_START      = 3'd2,
		REG_MEDIUM_START    = 3'd3,
		REG_FAST_START      = 3'd4,
		REG_SLOW_INTERVAL   = 3'd5,
		REG_MEDIUM_INTERVAL = 3'd6,
		REG_FAST_INTERVAL   = 3'd7
	} reg_index_t;

	localparam logic [7:0] RST_DEAD_ZONE       = 8'd16;
	localparam logic [7:0] RST_FAST_THRESHOLD  = 8'd80;
	localparam logic [7:0] RST_SLOW_START      = 8'd20;
	localparam logic [7:0] RST_MEDIUM_START    = 8'd12;
	localparam logic [7:0] RST_FAST_START      = 8'd6;
	localparam logic [7:0] RST_SLOW_INTERVAL   = 8'd9;
	localparam logic [7:0] RST_MEDIUM_INTERVAL = 8'd4;
	localparam logic [7:0] RST_FAST_INTERVAL   = 8'd2;

	typedef struct packed {
		logic [7:0] dead_zone;
		logic [7:0] fast_threshold;
		logic [7:0] slow_start;
		logic [7:0] medium_start;
		logic [7:0] fast_start;
		logic [7:0] slow_interval;
		logic [7:0] medium_interval;
		logic [7:0] fast_interval;
	} cfg_t;

	typedef struct packed {
		dir_t  dir;
		tier_t tier;
	} sample_t;

endpackage
`default_nettype wire

### src/mnar_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnar_cfg_regs
// Configuration register file: thresholds, start delays, repeat intervals.
// ----------------------------------------------------------------------------
module mnar_cfg_regs
	import mnar_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone       <= RST_DEAD_ZONE;
			cfg_q.fast_threshold  <= RST_FAST_THRESHOLD;
			cfg_q.slow_start      <= RST_SLOW_START;
			cfg_q.medium_start    <= RST_MEDIUM_START;
			cfg_q.fast_start      <= RST_FAST_START;
			cfg_q.slow_interval   <= RST_SLOW_INTERVAL;
			cfg_q.medium_interval <= RST_MEDIUM_INTERVAL;
			cfg_q.fast_interval   <= RST_FAST_INTERVAL;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_DEAD_ZONE:       cfg_q.dead_zone       <= cfg_data;
				REG_FAST_THRESHOLD:  cfg_q.fast_threshold  <= cfg_data;
				REG_SLOW_START:      cfg_q.slow_start      <= cfg_data;
				REG_MEDIUM_START:    cfg_q.medium_start    <= cfg_data;
				REG_FAST_START:      cfg_q.fast_start      <= cfg_data;
				REG_SLOW_INTERVAL:   cfg_q.slow_interval   <= cfg_data;
				REG_MEDIUM_INTERVAL: cfg_q.medium_interval <= cfg_data;
				REG_FAST_INTERVAL:   cfg_q.fast_interval   <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### src/mnar_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnar_classify
// Resolves d-pad and stick into this frame's direction and speed tier.
// ----------------------------------------------------------------------------
module mnar_classify
	import mnar_pkg::*;
(
	input  wire logic       up_held,
	input  wire logic       down_held,
	input  wire logic [7:0] stick_y,
	input  wire logic [7:0] dead_zone,
	input  wire logic [7:0] fast_threshold,
	output sample_t         smp
);

	logic       below;
	logic [7:0] mag;

	// offset from centre; 128 - 0 still fits in 8 bits
	assign below = stick_y < STICK_CENTRE;
	assign mag   = below ? (STICK_CENTRE - stick_y) : (stick_y - STICK_CENTRE);

	always_comb begin
		smp.dir  = DIR_NONE;
		smp.tier = TIER_NONE;
		priority if (up_held) begin
			smp.dir  = DIR_UP;
			smp.tier = TIER_MEDIUM;
		end else if (down_held) begin
			smp.dir  = DIR_DOWN;
			smp.tier = TIER_MEDIUM;
		end else if (mag >= dead_zone) begin
			smp.dir = below ? DIR_UP : DIR_DOWN;
			priority if (mag >= fast_threshold)
				smp.tier = TIER_FAST;
			else if (mag < MEDIUM_THRESHOLD)
				smp.tier = TIER_SLOW;
			else
				smp.tier = TIER_MEDIUM;
		end
	end

endmodule
`default_nettype wire

### src/mnar_repeat_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnar_repeat_core
// Hold state and repeat timing; decides the step for one frame.
// ----------------------------------------------------------------------------
module mnar_repeat_core
	import mnar_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    advance,
	input  wire sample_t smp,
	input  wire logic    skip_nav,
	input  wire logic    clear_nav,
	input  wire cfg_t    cfg,
	output dir_t         step,
	output tier_t        speed
);

	dir_t       held_dir_q,     held_dir_d;
	tier_t      held_speed_q,   held_speed_d;
	logic [7:0] hold_count_q,   hold_count_d;
	logic [7:0] repeat_phase_q, repeat_phase_d;

	logic [7:0] start;
	logic [7:0] interval;
	logic [7:0] hold_inc;
	logic [8:0] phase_inc;

	always_comb begin
		unique case (smp.tier)
			TIER_SLOW: begin
				start    = cfg.slow_start;
				interval = cfg.slow_interval;
			end
			TIER_FAST: begin
				start    = cfg.fast_start;
				interval = cfg.fast_interval;
			end
			TIER_NONE, TIER_MEDIUM: begin
				start    = cfg.medium_start;
				interval = cfg.medium_interval;
			end
		endcase
	end

	assign hold_inc  = hold_count_q + 8'd1;
	assign phase_inc = {1'b0, repeat_phase_q} + 9'd1;

	always_comb begin
		held_dir_d     = held_dir_q;
		held_speed_d   = held_speed_q;
		hold_count_d   = hold_count_q;
		repeat_phase_d = repeat_phase_q;
		step           = DIR_NONE;
		if (!skip_nav) begin
			priority if (smp.dir == DIR_NONE || smp.tier == TIER_NONE) begin
				held_dir_d     = DIR_NONE;
				held_speed_d   = TIER_NONE;
				hold_count_d   = '0;
				repeat_phase_d = '0;
			end else if (smp.dir != held_dir_q || smp.tier != held_speed_q) begin
				held_dir_d     = smp.dir;
				held_speed_d   = smp.tier;
				hold_count_d   = '0;
				repeat_phase_d = '0;
				step           = smp.dir;
			end else if (hold_count_q < start) begin
				hold_count_d = hold_inc;
				if (hold_inc == start) begin
					repeat_phase_d = '0;
					step           = smp.dir;
				end
			end else if (phase_inc >= {1'b0, interval}) begin
				repeat_phase_d = '0;
				step           = smp.dir;
			end else begin
				repeat_phase_d = phase_inc[7:0];
			end
		end
		// reported speed is taken before the clear
		speed = held_speed_d;
		if (clear_nav) begin
			held_dir_d     = DIR_NONE;
			held_speed_d   = TIER_NONE;
			hold_count_d   = '0;
			repeat_phase_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_dir_q     <= DIR_NONE;
			held_speed_q   <= TIER_NONE;
			hold_count_q   <= '0;
			repeat_phase_q <= '0;
		end else if (advance) begin
			held_dir_q     <= held_dir_d;
			held_speed_q   <= held_speed_d;
			hold_count_q   <= hold_count_d;
			repeat_phase_q <= repeat_phase_d;
		end
	end

endmodule
`default_nettype wire

### src/menu_nav_auto_repeat_unit.sv
`default_nettype none
// An accepted input transaction passes the input register, then the result register, to out_valid.
// Throughput: one transaction per cycle unless the result is stalled; the hold state
// updates in a single pass between the input register and the result register.
// in_stall rises only while the input register is full and the result is stalled.
// Reset: clears the hold state, empties both registers, and restores all
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
// menu_nav_auto_repeat_unit
// Menu cursor auto-repeat from d-pad and analog stick, one result per frame.
// ----------------------------------------------------------------------------
module menu_nav_auto_repeat_unit
	import mnar_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       up_held,
	input  wire logic       down_held,
	input  wire logic [7:0] stick_y,
	input  wire logic       skip_nav,
	input  wire logic       clear_nav,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      step_dir,
	output logic [1:0]      speed_tier
);

	cfg_t       cfg;
	sample_t    smp;
	dir_t       step;
	tier_t      speed;

	logic       valid_s1;
	logic       up_s1;
	logic       down_s1;
	logic [7:0] stick_s1;
	logic       skip_s1;
	logic       clear_s1;

	logic       out_valid_q;
	logic [1:0] step_dir_q;
	logic [1:0] speed_tier_q;

	logic       out_ready;
	logic       advance;
	logic       in_take;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_take   = in_valid && !in_stall;

	mnar_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mnar_classify u_classify (
		.up_held        (up_s1),
		.down_held      (down_s1),
		.stick_y        (stick_s1),
		.dead_zone      (cfg.dead_zone),
		.fast_threshold (cfg.fast_threshold),
		.smp            (smp)
	);

	mnar_repeat_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.smp       (smp),
		.skip_nav  (skip_s1),
		.clear_nav (clear_s1),
		.cfg       (cfg),
		.step      (step),
		.speed     (speed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			up_s1    <= up_held;
			down_s1  <= down_held;
			stick_s1 <= stick_y;
			skip_s1  <= skip_nav;
			clear_s1 <= clear_nav;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_dir_q   <= step;
			speed_tier_q <= speed;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_dir   = step_dir_q;
	assign speed_tier = speed_tier_q;

endmodule
`default_nettype wire

### bench/tb_menu_nav_auto_repeat_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_menu_nav_auto_repeat_unit
// Self-checking bench for the menu cursor auto-repeat unit. Frames flow in
// through a queue-fed driver and are checked against an in-bench copy of the
// hold/repeat logic. Random gaps and stalls run on both sides, and the
// register settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_menu_nav_auto_repeat_unit;
	import mnar_pkg::*;

	typedef struct packed {
		logic       up;
		logic       down;
		logic [7:0] y;
		logic       skip;
		logic       clr;
	} frame_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       up_held = 1'b0;
	logic       down_held = 1'b0;
	logic [7:0] stick_y = 8'h80;
	logic       skip_nav = 1'b0;
	logic       clear_nav = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] step_dir;
	logic [1:0] speed_tier;

	menu_nav_auto_repeat_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.up_held    (up_held),
		.down_held  (down_held),
		.stick_y    (stick_y),
		.skip_nav   (skip_nav),
		.clear_nav  (clear_nav),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.step_dir   (step_dir),
		.speed_tier (speed_tier)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("FAIL menu_nav_auto_repeat_unit");
		$finish;
	end

	frame_t     frames_todo[$];
	sample_t    step_due[$];
	int         n_queued = 0;
	int         n_taken = 0;
	int         fails = 0;
	logic       in_taken = 1'b0;
	logic       quiet = 1'b0;
	logic       hold_req = 1'b0;
	logic [7:0] cur_dz = RST_DEAD_ZONE;
	logic [7:0] cur_ft = RST_FAST_THRESHOLD;

	// predicted hold state and register copy
	logic [7:0] reg_shadow [8];
	dir_t       held_dir;
	tier_t      held_speed;
	logic [7:0] hold_count;
	logic [7:0] repeat_phase;

	task automatic clear_hold();
		held_dir = DIR_NONE;
		held_speed = TIER_NONE;
		hold_count = '0;
		repeat_phase = '0;
	endtask

	task automatic nav_frame(input frame_t f, output sample_t r);
		dir_t       d;
		dir_t       step;
		tier_t      t;
		logic       below;
		logic [7:0] mag;
		logic [7:0] lim;
		logic [7:0] gap;
		step = DIR_NONE;
		if (!f.skip) begin
			d = DIR_NONE;
			t = TIER_NONE;
			if (f.up) begin
				d = DIR_UP;
				t = TIER_MEDIUM;
			end else if (f.down) begin
				d = DIR_DOWN;
				t = TIER_MEDIUM;
			end else begin
				below = f.y < STICK_CENTRE;
				mag = below ? STICK_CENTRE - f.y : f.y - STICK_CENTRE;
				if (mag >= reg_shadow[REG_DEAD_ZONE]) begin
					d = below ? DIR_UP : DIR_DOWN;
					if (mag >= reg_shadow[REG_FAST_THRESHOLD])
						t = TIER_FAST;
					else if (mag < MEDIUM_THRESHOLD)
						t = TIER_SLOW;
					else
						t = TIER_MEDIUM;
				end
			end
			if (d == DIR_NONE) begin
				clear_hold();
			end else if (d != held_dir || t != held_speed) begin
				held_dir = d;
				held_speed = t;
				hold_count = '0;
				repeat_phase = '0;
				step = d;
			end else begin
				case (t)
					TIER_SLOW: begin
						lim = reg_shadow[REG_SLOW_START];
						gap = reg_shadow[REG_SLOW_INTERVAL];
					end
					TIER_FAST: begin
						lim = reg_shadow[REG_FAST_START];
						gap = reg_shadow[REG_FAST_INTERVAL];
					end
					default: begin
						lim = reg_shadow[REG_MEDIUM_START];
						gap = reg_shadow[REG_MEDIUM_INTERVAL];
					end
				endcase
				if (hold_count < lim) begin
					hold_count = hold_count + 8'd1;
					if (hold_count == lim) begin
						repeat_phase = '0;
						step = d;
					end
				end else if ({1'b0, repeat_phase} + 9'd1 >= {1'b0, gap}) begin
					repeat_phase = '0;
					step = d;
				end else begin
					repeat_phase = repeat_phase + 8'd1;
				end
			end
		end
		r.dir = step;
		r.tier = held_speed;
		if (f.clr)
			clear_hold();
	endtask

	// monitor: prediction on input transactions, check on output transactions
	always @(posedge clk) begin : monitor
		frame_t  f;
		sample_t due;
		if (!arst_n) begin
			reg_shadow[REG_DEAD_ZONE] = RST_DEAD_ZONE;
			reg_shadow[REG_FAST_THRESHOLD] = RST_FAST_THRESHOLD;
			reg_shadow[REG_SLOW_START] = RST_SLOW_START;
			reg_shadow[REG_MEDIUM_START] = RST_MEDIUM_START;
			reg_shadow[REG_FAST_START] = RST_FAST_START;
			reg_shadow[REG_SLOW_INTERVAL] = RST_SLOW_INTERVAL;
			reg_shadow[REG_MEDIUM_INTERVAL] = RST_MEDIUM_INTERVAL;
			reg_shadow[REG_FAST_INTERVAL] = RST_FAST_INTERVAL;
			clear_hold();
			in_taken <= 1'b0;
		end else begin
			if (cfg_we)
				reg_shadow[cfg_index] = cfg_data;
			if (in_valid && !in_stall) begin
				f = '{up_held, down_held, stick_y, skip_nav, clear_nav};
				nav_frame(f, due);
				step_due.push_back(due);
				n_taken++;
			end
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (step_due.size() == 0) begin
					$error("unexpected result: step_dir %b speed_tier %0d", step_dir,
						speed_tier);
					fails++;
				end else begin
					due = step_due.pop_front();
					if (step_dir !== due.dir) begin
						$error("step_dir: expected %b actual %b", due.dir, step_dir);
						fails++;
					end
					if (speed_tier !== due.tier) begin
						$error("speed_tier: expected %0d actual %0d", due.tier, speed_tier);
						fails++;
					end
				end
			end
		end
	end

	// driver: sender side with random gap bursts
	int send_gap = 0;
	int send_pct = 0;
	int send_tick = 0;

	always @(negedge clk) begin : driver
		frame_t f;
		send_tick++;
		if (send_tick % 64 == 0)
			case ($urandom_range(0, 2))
				0: send_pct = 0;
				1: send_pct = 10;
				default: send_pct = 40;
			endcase
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// stalled: hold the transaction as it is
		end else if (send_gap != 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (frames_todo.size() != 0) begin
			if (!quiet && $urandom_range(0, 99) < send_pct) begin
				send_gap = $urandom_range(1, 13) - 1;
				in_valid <= 1'b0;
			end else begin
				f = frames_todo.pop_front();
				up_held <= f.up;
				down_held <= f.down;
				stick_y <= f.y;
				skip_nav <= f.skip;
				clear_nav <= f.clr;
				in_valid <= 1'b1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: random stall bursts plus one long hold-off on request
	int   recv_gap = 0;
	int   recv_pct = 0;
	int   recv_tick = 0;
	int   hold_left = 0;
	logic hold_used = 1'b0;

	always @(negedge clk) begin : receiver
		logic stall_now;
		recv_tick++;
		if (recv_tick % 64 == 32)
			case ($urandom_range(0, 2))
				0: recv_pct = 0;
				1: recv_pct = 10;
				default: recv_pct = 40;
			endcase
		if (hold_req && !hold_used) begin
			hold_used = 1'b1;
			hold_left = 200;
		end
		if (hold_left != 0) begin
			hold_left--;
			stall_now = 1'b1;
		end else if (recv_gap != 0) begin
			recv_gap--;
			stall_now = 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < recv_pct) begin
			recv_gap = $urandom_range(1, 13) - 1;
			stall_now = 1'b1;
		end else begin
			stall_now = 1'b0;
		end
		out_stall <= stall_now;
	end

	task automatic queue_frame(input logic u, input logic d, input logic [7:0] y,
		input logic s, input logic c);
		frames_todo.push_back('{u, d, y, s, c});
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_taken != n_queued || step_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
	endtask

	// stick sample near one of the class boundaries, or anywhere
	function automatic logic [7:0] pick_stick();
		int edge_at;
		int off;
		int y;
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: edge_at = cur_dz;
			2: edge_at = cur_ft;
			default: edge_at = MEDIUM_THRESHOLD;
		endcase
		off = edge_at + $urandom_range(0, 2) - 1;
		if (off < 0) off = 0;
		if (off > 128) off = 128;
		y = $urandom_range(0, 1) ? 128 - off : 128 + off;
		if (y > 255) y = 255;
		return y[7:0];
	endfunction

	// mostly held runs of one direction and speed, with skips, clears and noise
	task automatic gen_frames(input int count, input int run_max);
		int         made;
		int         len;
		int         kind;
		frame_t     base;
		logic       s;
		logic       c;
		made = 0;
		while (made < count) begin
			kind = $urandom_range(0, 9);
			base = '{1'b0, 1'b0, pick_stick(), 1'b0, 1'b0};
			len = $urandom_range(1, run_max);
			case (kind)
				0: begin
					base.up = 1'b1;
					base.down = 1'($urandom_range(0, 1));
				end
				1: base.down = 1'b1;
				7: base.y = 8'(128 + $urandom_range(0, 6) - 3);
				8: begin
					base = 12'($urandom);
					len = 1;
				end
				default: ;
			endcase
			for (int i = 0; i < len && made < count; i++) begin
				s = base.skip | ($urandom_range(0, 15) == 0);
				c = base.clr | ($urandom_range(0, 31) == 0);
				queue_frame(base.up, base.down, base.y, s, c);
				made++;
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] dz, input logic [7:0] ft,
		input logic [7:0] ss, input logic [7:0] ms, input logic [7:0] fs,
		input logic [7:0] si, input logic [7:0] mi, input logic [7:0] fi,
		input int count);
		int lim;
		int gap;
		wait_idle();
		write_reg(REG_DEAD_ZONE, dz);
		write_reg(REG_FAST_THRESHOLD, ft);
		write_reg(REG_SLOW_START, ss);
		write_reg(REG_MEDIUM_START, ms);
		write_reg(REG_FAST_START, fs);
		write_reg(REG_SLOW_INTERVAL, si);
		write_reg(REG_MEDIUM_INTERVAL, mi);
		write_reg(REG_FAST_INTERVAL, fi);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_dz = dz;
		cur_ft = ft;
		lim = ss;
		if (ms > lim) lim = ms;
		if (fs > lim) lim = fs;
		gap = si;
		if (mi > gap) gap = mi;
		if (fi > gap) gap = fi;
		// dead zone of zero: a centred stick counts as down, slow unless the fast threshold is zero too
		if (dz == 8'd0)
			repeat (3) queue_frame(1'b0, 1'b0, 8'd128, 1'b0, 1'b0);
		gen_frames(count, lim + 3 * gap + 4);
	endtask

	function automatic logic [7:0] rand_delay();
		return 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) :
			$urandom_range(1, 24));
	endfunction

	initial begin : stimulus
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames at reset settings
		queue_frame(1'b1, 1'b0, 8'd128, 1'b0, 1'b0);
		queue_frame(1'b1, 1'b0, 8'd128, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b1, 8'd128, 1'b0, 1'b0);
		queue_frame(1'b1, 1'b1, 8'd0, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd255, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd128, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd113, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd112, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd167, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd168, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd207, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd208, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b1, 8'd128, 1'b1, 1'b0);
		queue_frame(1'b0, 1'b1, 8'd128, 1'b1, 1'b1);
		queue_frame(1'b1, 1'b0, 8'd128, 1'b0, 1'b1);
		queue_frame(1'b1, 1'b0, 8'd128, 1'b0, 1'b0);
		queue_frame(1'b1, 1'b1, 8'd255, 1'b1, 1'b1);
		queue_frame(1'b0, 1'b0, 8'd127, 1'b0, 1'b0);
		queue_frame(1'b0, 1'b0, 8'd129, 1'b0, 1'b0);
		// leave a direction held across the next register change
		queue_frame(1'b0, 1'b1, 8'd128, 1'b0, 1'b0);

		run_phase(8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 150);
		run_phase(8'd128, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 600);
		run_phase(8'd0, 8'd40, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 150);
		for (int p = 0; p < 6; p++) begin
			// one phase runs with the receiver held off while the sender keeps going
			hold_req = (p == 2);
			run_phase(8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)),
				rand_delay(), rand_delay(), rand_delay(), 8'($urandom_range(1, 16)),
				8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)), 140);
		end
		quiet = 1'b1;
		run_phase(RST_DEAD_ZONE, RST_FAST_THRESHOLD, RST_SLOW_START, RST_MEDIUM_START,
			RST_FAST_START, RST_SLOW_INTERVAL, RST_MEDIUM_INTERVAL, RST_FAST_INTERVAL, 150);
		wait_idle();
		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("PASS menu_nav_auto_repeat_unit");
		else
			$display("FAIL menu_nav_auto_repeat_unit");
		$finish;
	end

endmodule
`default_nettype wire
